FILE: rtl/core/aac_pkg.sv
// Package for the alarm arming controller: opcodes, reply codes, register
// indexes, reset values and the structs passed between the modules.
// No dependencies.
`default_nettype none

package aac_pkg;

    localparam int unsigned CNT_W    = 17;
    localparam int unsigned MUTE_W   = 16;
    localparam int unsigned MAXM_W   = 11;
    localparam int unsigned CFGIDX_W = 3;

    localparam logic [CNT_W-1:0]  GRACE_RESET    = CNT_W'(300);
    localparam logic [CNT_W-1:0]  WAKE_RESET     = CNT_W'(60);
    localparam logic [CNT_W-1:0]  COOLDOWN_RESET = CNT_W'(600);
    localparam logic [MAXM_W-1:0] MAX_MUTE_RESET = MAXM_W'(1440);

    typedef enum logic [2:0] {
        OP_IGNITION = 3'd0,
        OP_ARM_ON   = 3'd1,
        OP_ARM_OFF  = 3'd2,
        OP_MUTE     = 3'd3,
        OP_MOTION   = 3'd4,
        OP_DECAY    = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        REPLY_NONE       = 3'd0,
        REPLY_ARMED      = 3'd1,
        REPLY_DISARMED   = 3'd2,
        REPLY_MUTE_OFF   = 3'd3,
        REPLY_MUTE_ON    = 3'd4,
        REPLY_MUTE_RANGE = 3'd5
    } t_reply;

    typedef enum logic [CFGIDX_W-1:0] {
        CFG_GRACE    = 3'd0,
        CFG_WAKE     = 3'd1,
        CFG_COOLDOWN = 3'd2,
        CFG_MAX_MUTE = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]        opcode;
        logic              ignition;
        logic [MUTE_W-1:0] mute_minutes;
        logic              send_ok;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0]  grace_seconds;
        logic [CNT_W-1:0]  wake_step_seconds;
        logic [CNT_W-1:0]  cooldown_seconds;
        logic [MAXM_W-1:0] mute_limit_mins;
    } t_cfg;

    typedef struct packed {
        logic             armed;
        logic             manual_hold;
        logic [CNT_W-1:0] grace_left;
        logic [CNT_W-1:0] mute_left;
        logic [CNT_W-1:0] cooldown_left;
        logic             alert_request;
        t_reply           reply_code;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/alarm_arming_controller_top.sv
// Alarm arming controller top level: input register, execute stage, result register.
// A beat goes from the input register through the execute stage into the result register.
// Throughput: one beat per cycle while i_out_stall is low; single-pass state update.
// Reset (synchronous, active low) disarms, clears hold, mute and cooldown, loads grace 300
// and returns all configuration registers to their reset values.
// Depends on aac_pkg, aac_cfg_regs and aac_exec.
`default_nettype none

module alarm_arming_controller_top
    import aac_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CFGIDX_W-1:0] i_cfg_index,
    input  wire logic [CNT_W-1:0]    i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [2:0]          i_opcode,
    input  wire logic                i_ignition,
    input  wire logic [MUTE_W-1:0]   i_mute_minutes,
    input  wire logic                i_send_ok,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_armed,
    output logic                     o_manual_hold,
    output logic [CNT_W-1:0]         o_grace_left,
    output logic [CNT_W-1:0]         o_mute_left,
    output logic [CNT_W-1:0]         o_cooldown_left,
    output logic                     o_alert_request,
    output logic [2:0]               o_reply_code
);

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_vld;
    t_result r_res;
    logic    r_out_vld;
    t_result exec_res;
    logic    advance;
    logic    fire;

    aac_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign advance    = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && advance;
    assign o_in_stall = r_in_vld && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item.opcode       <= i_opcode;
            r_item.ignition     <= i_ignition;
            r_item.mute_minutes <= i_mute_minutes;
            r_item.send_ok      <= i_send_ok;
        end
    end

    aac_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (exec_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= exec_res;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_armed         = r_res.armed;
    assign o_manual_hold   = r_res.manual_hold;
    assign o_grace_left    = r_res.grace_left;
    assign o_mute_left     = r_res.mute_left;
    assign o_cooldown_left = r_res.cooldown_left;
    assign o_alert_request = r_res.alert_request;
    assign o_reply_code    = r_res.reply_code;

`ifndef SYNTHESIS
    a_alert_needs_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_alert_request) |-> (o_armed && (o_mute_left == '0)))
        else $error("alert beat while disarmed or muted");

    a_arm_on_clears_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_reply_code == REPLY_ARMED)) |->
        (o_armed && !o_manual_hold && (o_grace_left == '0)))
        else $error("arm reply with inconsistent state");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld && i_out_stall))
        else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/aac_cfg_regs.sv
// Configuration register bank of the alarm arming controller.
// Depends on aac_pkg.
`default_nettype none

module aac_cfg_regs
    import aac_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CFGIDX_W-1:0] i_cfg_index,
    input  wire logic [CNT_W-1:0]    i_cfg_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grace_seconds     <= GRACE_RESET;
            r_cfg.wake_step_seconds <= WAKE_RESET;
            r_cfg.cooldown_seconds  <= COOLDOWN_RESET;
            r_cfg.mute_limit_mins   <= MAX_MUTE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GRACE:    r_cfg.grace_seconds     <= i_cfg_data;
                CFG_WAKE:     r_cfg.wake_step_seconds <= i_cfg_data;
                CFG_COOLDOWN: r_cfg.cooldown_seconds  <= i_cfg_data;
                CFG_MAX_MUTE: r_cfg.mute_limit_mins   <= i_cfg_data[MAXM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/core/aac_exec.sv
// Execute stage: arming state registers and the single-pass update for one event.
// Depends on aac_pkg.
`default_nettype none

module aac_exec
    import aac_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_result    o_res
);

    logic             r_armed, n_armed;
    logic             r_manual, n_manual;
    logic [CNT_W-1:0] r_grace, n_grace;
    logic [CNT_W-1:0] r_mute, n_mute;
    logic [CNT_W-1:0] r_cool, n_cool;
    logic             alert;
    t_reply           reply;
    logic [CNT_W-1:0] mute_secs;

    // Minutes times sixty as a shift and subtract.
    assign mute_secs = {i_item.mute_minutes[CNT_W-7:0], 6'b0}
                     - {i_item.mute_minutes[CNT_W-3:0], 2'b0};

    always_comb begin
        n_armed  = r_armed;
        n_manual = r_manual;
        n_grace  = r_grace;
        n_mute   = r_mute;
        n_cool   = r_cool;
        alert    = 1'b0;
        reply    = REPLY_NONE;
        case (t_opcode'(i_item.opcode))
            OP_IGNITION: begin
                if (i_item.ignition) begin
                    n_armed  = 1'b0;
                    n_manual = 1'b0;
                    n_grace  = i_cfg.grace_seconds;
                end else if (r_manual) begin
                    n_armed = 1'b0;
                end else if (!r_armed) begin
                    if (r_grace > i_cfg.wake_step_seconds) begin
                        n_grace = r_grace - i_cfg.wake_step_seconds;
                    end else begin
                        n_grace = '0;
                        n_armed = 1'b1;
                    end
                end
            end
            OP_ARM_ON: begin
                n_armed  = 1'b1;
                n_manual = 1'b0;
                n_grace  = '0;
                reply    = REPLY_ARMED;
            end
            OP_ARM_OFF: begin
                n_armed  = 1'b0;
                n_manual = 1'b1;
                n_grace  = '0;
                reply    = REPLY_DISARMED;
            end
            OP_MUTE: begin
                if (i_item.mute_minutes > {{(MUTE_W-MAXM_W){1'b0}}, i_cfg.mute_limit_mins})
                begin
                    reply = REPLY_MUTE_RANGE;
                end else begin
                    n_mute = mute_secs;
                    reply  = (i_item.mute_minutes == '0) ? REPLY_MUTE_OFF : REPLY_MUTE_ON;
                end
            end
            OP_MOTION: begin
                if (r_armed && (r_mute == '0) && (r_cool == '0)) begin
                    alert = 1'b1;
                    if (i_item.send_ok) begin
                        n_cool = i_cfg.cooldown_seconds;
                    end
                end
            end
            OP_DECAY: begin
                n_mute = (r_mute > i_cfg.wake_step_seconds) ?
                         (r_mute - i_cfg.wake_step_seconds) : '0;
                n_cool = (r_cool > i_cfg.wake_step_seconds) ?
                         (r_cool - i_cfg.wake_step_seconds) : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed  <= 1'b0;
            r_manual <= 1'b0;
            r_grace  <= GRACE_RESET;
            r_mute   <= '0;
            r_cool   <= '0;
        end else if (i_fire) begin
            r_armed  <= n_armed;
            r_manual <= n_manual;
            r_grace  <= n_grace;
            r_mute   <= n_mute;
            r_cool   <= n_cool;
        end
    end

    always_comb begin
        o_res.armed         = n_armed;
        o_res.manual_hold   = n_manual;
        o_res.grace_left    = n_grace;
        o_res.mute_left     = n_mute;
        o_res.cooldown_left = n_cool;
        o_res.alert_request = alert;
        o_res.reply_code    = reply;
    end

endmodule

`default_nettype wire
